[design/jpt_pkg.sv]
// shared types and constants for the joystick pulse timer
// no dependencies; imported by every module of the block
package jpt_pkg;

    localparam int MAX_COUNT = 1023;
    localparam int COUNT_W   = $clog2(MAX_COUNT + 1);
    localparam int POS_W     = 10;
    localparam int POS_MAX   = (1 << POS_W) - 1;
    localparam int CMP_W     = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 32;
    localparam int CFG_AW    = 3;

    // operation codes
    localparam logic [1:0] OP_FIRST = 2'd0;
    localparam logic [1:0] OP_POLL  = 2'd1;
    localparam logic [1:0] OP_CAL   = 2'd2;

    // direction bits
    localparam logic [3:0] DIR_LEFT  = 4'd8;
    localparam logic [3:0] DIR_UP    = 4'd4;
    localparam logic [3:0] DIR_RIGHT = 4'd2;
    localparam logic [3:0] DIR_DOWN  = 4'd1;

    localparam logic [0:0] REG_STICK = 1'b0;

    typedef enum logic [2:0] {
        CAL_IDLE      = 3'd0,
        CAL_REL_CTR   = 3'd1,
        CAL_PRESS_CTR = 3'd2,
        CAL_REL_UL    = 3'd3,
        CAL_PRESS_UL  = 3'd4,
        CAL_REL_LR    = 3'd5,
        CAL_PRESS_LR  = 3'd6
    } cal_phase_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic [7:0] bits;
    } in_item_t;

    typedef struct packed {
        logic             fire;       // both axes low, result issued
        logic             begin_cal;  // start of calibration
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [1:0]       buttons;    // bit0 button one, bit1 button two
        logic             sat;
    } meas_t;

    // b + (t - b) / 2 with truncation toward zero, kept to POS_W bits
    function automatic logic [POS_W-1:0] half_toward(input logic [POS_W-1:0] b,
                                                     input logic [POS_W-1:0] t);
        logic signed [POS_W:0] d;
        logic signed [POS_W:0] h;
        logic        [POS_W:0] r;
        d = $signed({1'b0, t}) - $signed({1'b0, b});
        h = (d + $signed({{POS_W{1'b0}}, d[POS_W]})) >>> 1;
        r = {1'b0, b} + $unsigned(h);
        return r[POS_W-1:0];
    endfunction

endpackage

[design/joystick_pulse_timer_with_calibration_top.sv]
// top level of the game-port joystick pulse timer with calibration
// depends on jpt_pkg, jpt_in_stage, jpt_measure, jpt_calib
//
// usage
//  - slave stream: one word per game-port poll; operation selects first poll
//    after the one-shot trigger, further poll, or begin calibration
//  - master stream: one word per finished measurement, issued on the poll at
//    which both axis bits of the selected stick read low
//  - apb port: one register, stick_select at byte address 0; write it only
//    while the block is idle
//  - result path: the poll that ends the measurement is held in the input
//    register, worked on straight out of it, and lands in the result
//    register once that register is free or being drained
//  - throughput: one poll per cycle while the result register is free or
//    being drained; each poll is one tick of the pulse timebase, and all the
//    per-poll work fits between the input register and the result register
//  - reset: counters, captures, buttons, calibration phase, centre and
//    thresholds all clear; the stick register reads 0
//  - stall: while m_tready is low the result register holds; one more poll
//    can sit in the input register, after that s_tready drops
module joystick_pulse_timer_with_calibration_top (
    input  logic                       clk,
    input  logic                       rst_n,
    // slave stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,  // operation[1:0], port_bits[9:2], zeros
    // master stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,  // pos_x[9:0], pos_y[19:10], button_one[20],
                                                 // button_two[21], direction[25:22],
                                                 // timed_out[26], cal_phase[29:27], zeros
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [jpt_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import jpt_pkg::*;

    logic             stick_reg, stick_next;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_data_reg;
    logic             advance;
    logic             out_free;
    logic             cfg_wr;
    in_item_t         item;
    meas_t            meas;
    logic [3:0]       direction;
    cal_phase_t       phase_after;

    // apb register file: only stick_select, word index in paddr[2]
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign stick_next = (cfg_wr && (paddr[2] == REG_STICK)) ? pwdata[0] : stick_reg;
    assign prdata     = (paddr[2] == REG_STICK) ? {31'b0, stick_reg} : 32'b0;

    // a held poll moves on when the result register is free or being drained
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = item.valid && out_free;

    jpt_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .item     (item)
    );

    jpt_measure u_meas (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item         (item),
        .stick_select (stick_reg),
        .meas         (meas)
    );

    jpt_calib u_cal (
        .clk         (clk),
        .rst_n       (rst_n),
        .meas        (meas),
        .direction   (direction),
        .phase_after (phase_after)
    );

    // result register
    always_comb
    begin
        if (meas.fire)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            stick_reg   <= stick_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas.fire)
        begin
            m_data_reg <= {2'b00, 3'(phase_after), meas.sat, direction,
                           meas.buttons[1], meas.buttons[0], meas.y, meas.x};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule

[design/jpt_in_stage.sv]
// input register of the pulse timer: holds one accepted word
// depends on jpt_pkg
module jpt_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // operation[1:0], port_bits[9:2], zero pad
    input  logic              advance,
    output jpt_pkg::in_item_t item
);
    import jpt_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] op_reg;
    logic [7:0] bits_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg   <= s_tdata[1:0];
            bits_reg <= s_tdata[9:2];
        end
    end

    assign item.valid = valid_reg;
    assign item.op    = op_reg;
    assign item.bits  = bits_reg;
endmodule

[design/jpt_measure.sv]
// poll counter, axis captures, button latch and saturation flag
// depends on jpt_pkg
module jpt_measure (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  jpt_pkg::in_item_t item,
    input  logic              stick_select,
    output jpt_pkg::meas_t    meas
);
    import jpt_pkg::*;

    logic               measuring_reg, measuring_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0]   x_reg, x_next;
    logic [POS_W-1:0]   y_reg, y_next;
    logic [1:0]         btn_reg, btn_next;
    logic               sat_reg, sat_next;

    logic               first;
    logic               do_poll;
    logic               bit_x, bit_y, bit_b1, bit_b2;
    logic [COUNT_W-1:0] cnt_eff;
    logic [POS_W-1:0]   x_eff, y_eff, cap;
    logic [1:0]         btn_eff;
    logic               sat_eff;
    logic               axes_low;

    always_comb
    begin
        first   = advance && (item.op == OP_FIRST);
        do_poll = first || (advance && (item.op == OP_POLL) && measuring_reg);

        bit_x  = stick_select ? item.bits[2] : item.bits[0];
        bit_y  = stick_select ? item.bits[3] : item.bits[1];
        bit_b1 = stick_select ? item.bits[6] : item.bits[4];
        bit_b2 = stick_select ? item.bits[7] : item.bits[5];

        // a first poll restarts everything before it is counted
        cnt_eff = first ? '0 : count_reg;
        x_eff   = first ? '0 : x_reg;
        y_eff   = first ? '0 : y_reg;
        sat_eff = first ? 1'b0 : sat_reg;
        btn_eff = first ? {~bit_b2, ~bit_b1} : btn_reg;

        if (CMP_W'(cnt_eff) > CMP_W'(POS_MAX))
            cap = POS_W'(POS_MAX);
        else
            cap = POS_W'(cnt_eff);

        axes_low = !bit_x && !bit_y;

        measuring_next = measuring_reg;
        count_next     = cnt_eff;
        x_next         = x_eff;
        y_next         = y_eff;
        btn_next       = btn_eff;
        sat_next       = sat_eff;

        if (do_poll)
        begin
            if (axes_low)
            begin
                measuring_next = 1'b0;
            end
            else
            begin
                measuring_next = 1'b1;
                if (bit_x)
                    x_next = cap;
                if (bit_y)
                    y_next = cap;
                if (CMP_W'(cnt_eff) < CMP_W'(MAX_COUNT))
                    count_next = cnt_eff + COUNT_W'(1);
                else
                    sat_next = 1'b1;
            end
        end

        meas.fire      = do_poll && axes_low;
        meas.begin_cal = advance && (item.op == OP_CAL);
        meas.x         = x_eff;
        meas.y         = y_eff;
        meas.buttons   = btn_eff;
        meas.sat       = sat_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measuring_reg <= 1'b0;
            count_reg     <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            btn_reg       <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            measuring_reg <= measuring_next;
            count_reg     <= count_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            btn_reg       <= btn_next;
            sat_reg       <= sat_next;
        end
    end
endmodule

[design/jpt_calib.sv]
// calibration sequencer, centre and threshold registers, direction compare
// depends on jpt_pkg
module jpt_calib (
    input  logic                      clk,
    input  logic                      rst_n,
    input  jpt_pkg::meas_t            meas,
    output logic [3:0]                direction,
    output jpt_pkg::cal_phase_t       phase_after
);
    import jpt_pkg::*;

    cal_phase_t       phase_reg, phase_next;
    logic [POS_W-1:0] ctr_x_reg, ctr_x_next, ctr_y_reg, ctr_y_next;
    logic [POS_W-1:0] thr_l_reg, thr_l_next, thr_u_reg, thr_u_next;
    logic [POS_W-1:0] thr_r_reg, thr_r_next, thr_d_reg, thr_d_next;
    logic             pressed;
    logic [POS_W-1:0] half_x, half_y;

    always_comb
    begin
        // compare against thresholds held before this update
        direction = '0;
        if (meas.x <= thr_l_reg) direction = direction | DIR_LEFT;
        if (meas.y <= thr_u_reg) direction = direction | DIR_UP;
        if (meas.x >= thr_r_reg) direction = direction | DIR_RIGHT;
        if (meas.y >= thr_d_reg) direction = direction | DIR_DOWN;
    end

    always_comb
    begin
        pressed    = |meas.buttons;
        half_x     = half_toward(ctr_x_reg, meas.x);
        half_y     = half_toward(ctr_y_reg, meas.y);
        phase_next = phase_reg;
        ctr_x_next = ctr_x_reg;
        ctr_y_next = ctr_y_reg;
        thr_l_next = thr_l_reg;
        thr_u_next = thr_u_reg;
        thr_r_next = thr_r_reg;
        thr_d_next = thr_d_reg;

        if (meas.fire)
        begin
            unique case (phase_reg)
                CAL_REL_CTR:   if (!pressed) phase_next = CAL_PRESS_CTR;
                CAL_REL_UL:    if (!pressed) phase_next = CAL_PRESS_UL;
                CAL_REL_LR:    if (!pressed) phase_next = CAL_PRESS_LR;
                CAL_PRESS_CTR:
                begin
                    if (pressed)
                    begin
                        ctr_x_next = meas.x;
                        ctr_y_next = meas.y;
                        phase_next = CAL_REL_UL;
                    end
                end
                CAL_PRESS_UL:
                begin
                    if (pressed)
                    begin
                        thr_l_next = half_x;
                        thr_u_next = half_y;
                        phase_next = CAL_REL_LR;
                    end
                end
                CAL_PRESS_LR:
                begin
                    if (pressed)
                    begin
                        thr_r_next = half_x;
                        thr_d_next = half_y;
                        phase_next = CAL_IDLE;
                    end
                end
                default:       phase_next = CAL_IDLE;
            endcase
        end
        else if (meas.begin_cal)
        begin
            ctr_x_next = '0;
            ctr_y_next = '0;
            phase_next = pressed ? CAL_REL_CTR : CAL_PRESS_CTR;
        end

        phase_after = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= CAL_IDLE;
            ctr_x_reg <= '0;
            ctr_y_reg <= '0;
            thr_l_reg <= '0;
            thr_u_reg <= '0;
            thr_r_reg <= '0;
            thr_d_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ctr_x_reg <= ctr_x_next;
            ctr_y_reg <= ctr_y_next;
            thr_l_reg <= thr_l_next;
            thr_u_reg <= thr_u_next;
            thr_r_reg <= thr_r_next;
            thr_d_reg <= thr_d_next;
        end
    end
endmodule

[bench/tb_joystick_pulse_timer_with_calibration_top.sv]
`timescale 1ns / 1ps
// self-checking bench for joystick_pulse_timer_with_calibration_top: directed polls, then
// random measurements and calibration runs checked against an in-bench predictor
// depends on jpt_pkg and the design sources only
module tb_joystick_pulse_timer_with_calibration_top;

    import jpt_pkg::*;

    // unused operation code, the block must ignore it
    localparam logic [1:0]        OP_SPARE   = 2'd3;
    localparam logic [CFG_AW-1:0] STICK_ADDR = CFG_AW'({REG_STICK, 2'b00});
    localparam int                HOLD_SPAN  = 300;
    localparam int                PHASE_POLLS = 100;

    // one result word, pos_x in the lowest bits as on m_tdata
    typedef struct packed {
        cal_phase_t       phase;
        logic             timed_out;
        logic [3:0]       dir;
        logic             btn2;
        logic             btn1;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] x;
    } reading_t;

    // one directed poll, with a hand-written result where it is obvious
    typedef struct packed {
        logic       stick;
        logic [1:0] op;
        logic [7:0] bits;
        logic       fixed;
        reading_t   want;
    } poll_row_t;

    // with all thresholds at zero every direction bit is set
    localparam reading_t CENTRE_PRESSED = '{phase: CAL_IDLE, timed_out: 1'b0,
        dir: DIR_LEFT | DIR_UP | DIR_RIGHT | DIR_DOWN, btn2: 1'b1, btn1: 1'b1, y: '0, x: '0};
    localparam reading_t CENTRE_RELEASED = '{phase: CAL_IDLE, timed_out: 1'b0,
        dir: DIR_LEFT | DIR_UP | DIR_RIGHT | DIR_DOWN, btn2: 1'b0, btn1: 1'b0, y: '0, x: '0};

    localparam int N_ROWS = 25;
    localparam poll_row_t PLAN [0:N_ROWS-1] = '{
        // both axes already low on the first poll, buttons down, straight after reset
        '{1'b0, OP_FIRST, 8'h00, 1'b1, CENTRE_PRESSED},
        // every other bit high, buttons up
        '{1'b0, OP_FIRST, 8'hFC, 1'b1, CENTRE_RELEASED},
        // further poll while idle and the unused operation: no word
        '{1'b0, OP_POLL,  8'hFF, 1'b0, '0},
        '{1'b0, OP_SPARE, 8'hFF, 1'b0, '0},
        // short pulse, y falls first
        '{1'b0, OP_FIRST, 8'h33, 1'b0, '0},
        '{1'b0, OP_POLL,  8'h31, 1'b0, '0},
        '{1'b0, OP_POLL,  8'hC0, 1'b0, '0},
        // calibration with nothing latched goes straight to waiting for a press
        '{1'b0, OP_CAL,   8'h00, 1'b0, '0},
        // centre at x 0, y 3
        '{1'b0, OP_FIRST, 8'h03, 1'b0, '0},
        '{1'b0, OP_POLL,  8'h02, 1'b0, '0},
        '{1'b0, OP_POLL,  8'h02, 1'b0, '0},
        '{1'b0, OP_POLL,  8'h02, 1'b0, '0},
        '{1'b0, OP_POLL,  8'h00, 1'b0, '0},
        // release, press at the origin: negative half step rounds toward zero
        '{1'b0, OP_FIRST, 8'h30, 1'b0, '0},
        '{1'b0, OP_FIRST, 8'h00, 1'b0, '0},
        '{1'b0, OP_FIRST, 8'h30, 1'b0, '0},
        '{1'b0, OP_FIRST, 8'h00, 1'b0, '0},
        // calibration begun mid-measurement, then a first poll restarts it
        '{1'b0, OP_FIRST, 8'h0F, 1'b0, '0},
        '{1'b0, OP_CAL,   8'hFF, 1'b0, '0},
        '{1'b0, OP_FIRST, 8'h23, 1'b0, '0},
        '{1'b0, OP_POLL,  8'h00, 1'b0, '0},
        // second stick, the first stick's bits are noise
        '{1'b1, OP_FIRST, 8'hFF, 1'b0, '0},
        '{1'b1, OP_POLL,  8'h74, 1'b0, '0},
        '{1'b1, OP_POLL,  8'hF3, 1'b0, '0},
        '{1'b1, OP_FIRST, 8'h30, 1'b0, '0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;   // operation[1:0], port_bits[9:2], zeros
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // pos_x[9:0], pos_y[19:10], button_one[20], button_two[21],
                                  // direction[25:22], timed_out[26], cal_phase[29:27], zeros
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // hand-written result travelling beside the word on the slave side
    logic              s_fixed;
    reading_t          s_fixed_val;

    // predictor state, a copy of what the block should hold
    logic               stick;
    logic               measuring;
    logic [COUNT_W-1:0] tick_count;
    logic [POS_W-1:0]   x_cap;
    logic [POS_W-1:0]   y_cap;
    logic [1:0]         btn;        // bit0 button one, bit1 button two
    logic               sat;
    cal_phase_t         phase;
    logic [POS_W-1:0]   centre_x;
    logic [POS_W-1:0]   centre_y;
    logic [POS_W-1:0]   thr_left;
    logic [POS_W-1:0]   thr_up;
    logic [POS_W-1:0]   thr_right;
    logic [POS_W-1:0]   thr_down;

    reading_t    readings_due [$];
    int unsigned mismatches = 0;
    int unsigned burst_left = 0;
    bit          hold_req = 1'b0;

    joystick_pulse_timer_with_calibration_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // b + (t - b) / 2, the division truncating toward zero
    function automatic logic [POS_W-1:0] halfway_point(input logic [POS_W-1:0] from_pt,
                                                       input logic [POS_W-1:0] to_pt);
        int diff;
        diff = int'(to_pt) - int'(from_pt);
        return POS_W'(int'(from_pt) + diff / 2);
    endfunction

    // one tick of the pulse timebase; ends the measurement once both axes read low
    task automatic take_poll(input logic [7:0] c, output logic produced, output reading_t r);
        logic x_hi;
        logic y_hi;
        logic pressed;
        x_hi = stick ? c[2] : c[0];
        y_hi = stick ? c[3] : c[1];
        produced = 1'b0;
        r = '0;
        if (!x_hi && !y_hi)
        begin
            measuring = 1'b0;
            r.x = x_cap;
            r.y = y_cap;
            r.btn1 = btn[0];
            r.btn2 = btn[1];
            r.timed_out = sat;
            // directions use the thresholds from before this word's calibration step
            if (x_cap <= thr_left)  r.dir |= DIR_LEFT;
            if (y_cap <= thr_up)    r.dir |= DIR_UP;
            if (x_cap >= thr_right) r.dir |= DIR_RIGHT;
            if (y_cap >= thr_down)  r.dir |= DIR_DOWN;
            pressed = (btn != 2'b00);
            case (phase)
                CAL_REL_CTR, CAL_REL_UL, CAL_REL_LR:
                    if (!pressed) phase = cal_phase_t'(phase + 3'd1);
                CAL_PRESS_CTR:
                    if (pressed)
                    begin
                        centre_x = x_cap;
                        centre_y = y_cap;
                        phase = CAL_REL_UL;
                    end
                CAL_PRESS_UL:
                    if (pressed)
                    begin
                        thr_left = halfway_point(centre_x, x_cap);
                        thr_up   = halfway_point(centre_y, y_cap);
                        phase = CAL_REL_LR;
                    end
                CAL_PRESS_LR:
                    if (pressed)
                    begin
                        thr_right = halfway_point(centre_x, x_cap);
                        thr_down  = halfway_point(centre_y, y_cap);
                        phase = CAL_IDLE;
                    end
                default:
                    phase = CAL_IDLE;
            endcase
            r.phase = phase;
            produced = 1'b1;
        end
        else
        begin
            if (x_hi) x_cap = (tick_count > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(tick_count);
            if (y_hi) y_cap = (tick_count > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(tick_count);
            if (tick_count < MAX_COUNT)
                tick_count = tick_count + 1'b1;
            else
                sat = 1'b1;
            measuring = 1'b1;
        end
    endtask

    task automatic predict_word(input logic [1:0] op, input logic [7:0] c,
                                output logic produced, output reading_t r);
        produced = 1'b0;
        r = '0;
        case (op)
            OP_FIRST:
            begin
                // buttons are active low
                btn[0] = ~(stick ? c[6] : c[4]);
                btn[1] = ~(stick ? c[7] : c[5]);
                tick_count = '0;
                x_cap = '0;
                y_cap = '0;
                sat = 1'b0;
                take_poll(c, produced, r);
            end
            OP_POLL:
                if (measuring) take_poll(c, produced, r);
            OP_CAL:
            begin
                centre_x = '0;
                centre_y = '0;
                phase = (btn != 2'b00) ? CAL_REL_CTR : CAL_PRESS_CTR;
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_reading(input reading_t want, input logic [31:0] word);
        reading_t got;
        got = reading_t'(word[29:0]);
        report_field("pos_x", want.x, got.x);
        report_field("pos_y", want.y, got.y);
        report_field("button_one", want.btn1, got.btn1);
        report_field("button_two", want.btn2, got.btn2);
        report_field("direction", want.dir, got.dir);
        report_field("timed_out", want.timed_out, got.timed_out);
        report_field("cal_phase", want.phase, got.phase);
        report_field("padding", 0, word[31:30]);
    endtask

    // both handshakes sampled at the edge, before any stimulus update lands;
    // the result check goes first so a word never meets its own prediction
    always @(posedge clk)
    begin
        logic     produced;
        reading_t predicted;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (readings_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none got %h", $time, m_tdata);
                    mismatches++;
                end
                else
                    compare_reading(readings_due.pop_front(), m_tdata);
            end
            if (s_tvalid && s_tready)
            begin
                predict_word(s_tdata[1:0], s_tdata[9:2], produced, predicted);
                if (produced) readings_due.push_back(s_fixed ? s_fixed_val : predicted);
            end
        end
    end

    // ---------------------------------------------------------------- sender

    // offers one word and returns at the edge that takes it; bursts of random
    // length, mostly with idle gaps in between
    task automatic send_word(input logic [1:0] op, input logic [7:0] bits,
                             input logic fixed, input reading_t want);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid    <= 1'b1;
        s_tdata     <= {6'b0, bits, op};
        s_fixed     <= fixed;
        s_fixed_val <= want;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // stops offering, lets every expected word arrive, then covers a poll
    // that is still in the input register without causing a word; the first
    // edge lets the monitor log the last accepted word
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write of the stick register, then a read back
    task automatic write_stick(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STICK_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        stick = value;
        // read back, psel stays high into the next setup cycle
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== 32'(value))
        begin
            $display("%0t: stick_select read expected %0d got %0d", $time, value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one measurement: x high for the first lx polls, y for the first ly, then
    // one poll with both low; noisy runs scramble axis bits now and then
    task automatic run_reading(input int unsigned lx, input int unsigned ly,
                               input bit noisy, output int unsigned n_polls);
        int unsigned last;
        int unsigned i;
        logic [7:0]  c;
        logic [1:0]  press;
        logic        xh;
        logic        yh;
        last = (lx > ly) ? lx : ly;
        // half the time both released, otherwise some button held
        press = ($urandom_range(0, 1) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
        n_polls = 0;
        for (i = 0; i <= last; i++)
        begin
            c = 8'($urandom_range(0, 255));
            xh = (i < lx);
            yh = (i < ly);
            if (noisy && $urandom_range(0, 7) == 0)
            begin
                xh = 1'($urandom_range(0, 1));
                yh = 1'($urandom_range(0, 1));
            end
            if (stick)
            begin
                c[2] = xh;
                c[3] = yh;
                c[6] = ~press[0];
                c[7] = ~press[1];
            end
            else
            begin
                c[0] = xh;
                c[1] = yh;
                c[4] = ~press[0];
                c[5] = ~press[1];
            end
            // a pulse long enough to saturate the count runs without strays
            if (i != 0 && last <= MAX_COUNT)
            begin
                // stray words in the middle of a measurement
                case ($urandom_range(0, 199))
                    0: send_word(OP_CAL, 8'($urandom_range(0, 255)), 1'b0, '0);
                    1: send_word(OP_SPARE, 8'($urandom_range(0, 255)), 1'b0, '0);
                    2: send_word(OP_FIRST, 8'($urandom_range(0, 255)), 1'b0, '0);
                    default: ;
                endcase
            end
            send_word((i == 0) ? OP_FIRST : OP_POLL, c, 1'b0, '0);
            n_polls++;
        end
    endtask

    // ---------------------------------------------------------------- receiver

    // stretches of always ready, coin flips, one in four, and mostly ready;
    // a hold request parks tready low for a long stretch
    initial
    begin : receiver
        int unsigned mode;
        int unsigned span;
        int unsigned beat;
        m_tready <= 1'b0;
        beat = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            repeat (span)
            begin
                @(posedge clk);
                beat++;
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    m_tready <= 1'b0;
                    repeat (HOLD_SPAN) @(posedge clk);
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (beat % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- main flow

    initial
    begin : stimulus
        int          row;
        int          ph;
        int unsigned done_polls;
        int unsigned n;
        int unsigned pick;
        int unsigned lim;
        bit          paused;

        // every input known from time zero
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_fixed     <= 1'b0;
        s_fixed_val <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;

        // predictor at its reset state
        stick = 1'b0;
        measuring = 1'b0;
        tick_count = '0;
        x_cap = '0;
        y_cap = '0;
        btn = 2'b00;
        sat = 1'b0;
        phase = CAL_IDLE;
        centre_x = '0;
        centre_y = '0;
        thr_left = '0;
        thr_up = '0;
        thr_right = '0;
        thr_down = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_stick(1'b0);

        // directed rows, the register changes only between drained stretches
        for (row = 0; row < N_ROWS; row++)
        begin
            if (PLAN[row].stick != stick)
            begin
                wait_idle();
                write_stick(PLAN[row].stick);
            end
            send_word(PLAN[row].op, PLAN[row].bits, PLAN[row].fixed, PLAN[row].want);
        end

        // random phases, each under its own stick setting; the first opens
        // with a pulse long enough to saturate the count
        for (ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            write_stick((ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
            if (ph == 1) hold_req = 1'b1;
            paused = 1'b0;
            done_polls = 0;
            if (ph == 0) run_reading(MAX_COUNT + 7, $urandom_range(0, MAX_COUNT + 17),
                                     1'b0, n);
            while (done_polls < PHASE_POLLS)
            begin
                // halfway through, let the block run dry before going on
                if (ph == 1 && !paused && done_polls > PHASE_POLLS / 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_word(OP_CAL, 8'($urandom_range(0, 255)), 1'b0, '0);
                else if (pick < 7)
                    send_word(OP_POLL, 8'($urandom_range(0, 255)), 1'b0, '0);
                else if (pick < 9)
                    send_word(OP_SPARE, 8'($urandom_range(0, 255)), 1'b0, '0);
                else
                begin
                    pick = $urandom_range(0, 99);
                    lim = (pick < 70) ? 12 : (pick < 95) ? 60 : 400;
                    run_reading($urandom_range(0, lim), $urandom_range(0, lim),
                                ($urandom_range(0, 5) == 0), n);
                    done_polls += n;
                end
            end
        end

        // drain, then keep watching to catch any stray word
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && readings_due.size() == 0)
            $display("joystick_pulse_timer_with_calibration_top test passed");
        else
            $display("joystick_pulse_timer_with_calibration_top test failed");
        $finish;
    end

    // generous limit, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("joystick_pulse_timer_with_calibration_top test failed");
        $finish;
    end

endmodule
